[rtl/core/bes_pkg.sv]
// Shared constants, types and codes for the Bezier easing sampler.
`timescale 1ns / 1ps
package bes_pkg;

  localparam int MAX_SEGMENTS = 8;
  localparam int BISECT_STEPS = 14;
  localparam int WORD_DEPTH   = 6 * MAX_SEGMENTS - 2;
  localparam int ADDR_W       = $clog2(WORD_DEPTH);
  localparam int SEG_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int STEP_W       = $clog2(BISECT_STEPS);

  // Field widths
  localparam int COORD_W = 24;
  localparam int IDX_W   = 16;
  localparam int WIDX_W  = 6;

  // Divider widths: numerator ((i+1)<<16)+den/2, divisor count+1
  localparam int NUM_W = 33;
  localparam int DEN_W = 17;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_OUTPUT = 2'd2;

  // Commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[rtl/core/bes_if.sv]
// Stream interfaces for the sampler's input and result channels.
`timescale 1ns / 1ps
interface bes_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [bes_pkg::WIDX_W-1:0]          word_index;
  logic signed [bes_pkg::COORD_W-1:0]  word_value;
  logic [bes_pkg::IDX_W-1:0]           sample_index;

  modport source (output valid, cmd, word_index, word_value, sample_index, input ready);
  modport sink   (input valid, cmd, word_index, word_value, sample_index, output ready);
endinterface

interface bes_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bes_pkg::COORD_W-1:0]  value;
  logic [bes_pkg::IDX_W-1:0]           echo_index;

  modport source (output valid, value, echo_index, input ready);
  modport sink   (input valid, value, echo_index, output ready);
endinterface

[rtl/core/bes_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bes_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bes_pkg::div_ctl_t           ctl,
  input  logic [bes_pkg::NUM_W-1:0]   num,
  input  logic [bes_pkg::DEN_W-1:0]   den,
  output bes_pkg::div_sts_t           sts,
  output logic [bes_pkg::NUM_W-1:0]   quo
);

  localparam int BIT_W = $clog2(bes_pkg::NUM_W + 1);

  logic                        busy_r, done_r;
  logic [BIT_W-1:0]            cnt_r;
  logic [bes_pkg::NUM_W-1:0]   num_r, quo_r;
  logic [bes_pkg::DEN_W-1:0]   den_r, rem_r;
  logic [bes_pkg::DEN_W:0]     trial;
  logic                        fits;

  // shift in the next numerator bit and try the subtraction
  assign trial = {rem_r, num_r[bes_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= BIT_W'(bes_pkg::NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == BIT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[bes_pkg::NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[bes_pkg::NUM_W-2:0], fits};
      rem_r <= fits ? bes_pkg::DEN_W'(trial - {1'b0, den_r}) : bes_pkg::DEN_W'(trial);
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

[rtl/core/bezier_easing_sampler.sv]
// Top level of the piecewise cubic Bezier easing sampler.
//
// Channels: in_ch carries commands. cmd=0 writes one curve word into the
// 46-word store (index past the store is dropped). cmd=1 asks for sample i;
// the block answers on out_ch with y at t=(i+1)/(sample_count+1) and
// echoes i. Registers are written on cfg_we. A sample runs in steps: the
// serial divide forming t, the join search over the segments, the fetch of
// the segment's eight coordinates over the single memory read port, the
// bisection (14 steps) and the rounding. Its pace is set by the one shared
// 32x32 multiplier, which does fourteen products per bisection step.
// One item is worked at a time; in_ch.ready is low while a sample runs.
// A finished result sits in the output register; the next item is taken
// while it waits, but a second result waits until the first is transferred.
// Reset (rst_n low, synchronous) returns the sequencer to idle, drops any
// held result and restores segment_count=1, sample_count=1, integer mode off.
// Curve words are undefined until written; there is no clearing pass.
`timescale 1ns / 1ps
module bezier_easing_sampler (
  input  logic                            clk,
  input  logic                            rst_n,
  bes_in_if.sink                          in_ch,
  bes_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bes_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int C_W   = bes_pkg::COORD_W;
  localparam int P_W   = 31;
  localparam int ACC_W = 58;
  localparam int XY_W  = 28;
  localparam int AW2   = $clog2(6 * bes_pkg::MAX_SEGMENTS + 2);
  localparam int CNT_W_L = bes_pkg::CNT_W;
  localparam logic [P_W-1:0] ONE30  = P_W'(64'h4000_0000);
  localparam logic [P_W-1:0] HALF30 = P_W'(64'h2000_0000);

  // sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV    = 4'd1;
  localparam logic [3:0] ST_SRCH   = 4'd2;
  localparam logic [3:0] ST_SRCH_D = 4'd3;
  localparam logic [3:0] ST_LD_A   = 4'd4;
  localparam logic [3:0] ST_LD_D   = 4'd5;
  localparam logic [3:0] ST_BIS    = 4'd6;
  localparam logic [3:0] ST_FIN_M  = 4'd7;
  localparam logic [3:0] ST_FIN_R  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  // bisection micro-ops
  localparam logic [4:0] OP_LAST_MUL = 5'd13;
  localparam logic [4:0] OP_DECIDE   = 5'd15;
  localparam logic [4:0] OP_NEXT     = 5'd16;

  localparam logic [13:0] SCALE = 14'd10000;

  // configuration registers
  logic [3:0]                 seg_cnt_r;
  logic [bes_pkg::IDX_W-1:0]  smp_cnt_r;
  logic                       int_out_r;

  // sequencer and payload registers
  logic [3:0]                 state_r, state_nxt;
  logic [CNT_W_L-1:0]         n_r;
  logic [bes_pkg::SEG_W-1:0]  k_r, seg_r;
  logic [2:0]                 o_r;
  logic [4:0]                 op_r;
  logic [bes_pkg::STEP_W-1:0] step_r;
  logic [bes_pkg::NUM_W-1:0]  t_r;
  logic [bes_pkg::IDX_W-1:0]  sidx_r;
  logic signed [C_W-1:0]      cx_r [4];
  logic signed [C_W-1:0]      cy_r [4];
  logic [P_W-1:0]             lo_r, hi_r, p_r, u_r;
  logic [P_W-1:0]             p2_r, u2_r, ka_r, kb_r, kc_r, kd_r;
  logic signed [ACC_W-1:0]    accx_r, accy_r;
  logic signed [XY_W-1:0]     y_r;
  logic signed [C_W-1:0]      res_r;
  logic                       out_valid_r;
  logic signed [C_W-1:0]      out_value_r;
  logic [bes_pkg::IDX_W-1:0]  out_idx_r;

  // curve store
  logic signed [C_W-1:0]      mem [bes_pkg::WORD_DEPTH];
  logic signed [C_W-1:0]      rdata_r;
  logic [bes_pkg::ADDR_W-1:0] rd_addr;

  // shared multiplier
  logic signed [31:0]         mul_a, mul_b;
  logic signed [63:0]         prod_r;

  // divider
  bes_pkg::div_ctl_t          div_ctl;
  bes_pkg::div_sts_t          div_sts;
  logic [bes_pkg::NUM_W-1:0]  div_num, div_quo;
  logic [bes_pkg::DEN_W-1:0]  div_den;

  logic                       in_xfer, out_xfer, is_sample, last_seg;
  logic [AW2-1:0]             ld_pos;
  logic [AW2-1:0]             srch_pos;
  logic [P_W-1:0]             rnd_u, rnd_3u, mid;
  logic [65:0]                prod3;
  logic signed [XY_W-1:0]     x_cur, y_cur;
  logic signed [C_W-1:0]      y_sat;
  logic [C_W-1:0]             y_mag;
  logic [C_W-1:0]             r_int;
  logic                       go_lo;
  logic [CNT_W_L-1:0]         n_eff;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign is_sample    = in_ch.cmd == bes_pkg::CMD_SAMPLE;
  assign out_xfer     = out_valid_r && out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.echo_index = out_idx_r;

  // segment count clamped to 1..MAX_SEGMENTS
  always_comb begin
    priority if (seg_cnt_r == 4'd0) n_eff = CNT_W_L'(1);
    else if (32'(seg_cnt_r) > bes_pkg::MAX_SEGMENTS) n_eff = CNT_W_L'(bes_pkg::MAX_SEGMENTS);
    else n_eff = CNT_W_L'(seg_cnt_r);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= 4'd1;
      smp_cnt_r <= bes_pkg::IDX_W'(1);
      int_out_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bes_pkg::CFG_SEGMENT_COUNT:  seg_cnt_r <= cfg_data[3:0];
        bes_pkg::CFG_SAMPLE_COUNT:   smp_cnt_r <= cfg_data[bes_pkg::IDX_W-1:0];
        bes_pkg::CFG_INTEGER_OUTPUT: int_out_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // t = ((i+1)<<16 + den/2) / den
  assign div_ctl.start = in_xfer && is_sample;
  assign div_den = bes_pkg::DEN_W'(smp_cnt_r) + 1'b1;
  assign div_num = {(bes_pkg::DEN_W'(in_ch.sample_index) + 1'b1), 16'd0}
                   + bes_pkg::NUM_W'(div_den[bes_pkg::DEN_W-1:1]);

  bes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  // memory read address: join x during search, coordinates during load
  assign srch_pos = AW2'(6 * k_r) + AW2'(4);
  assign ld_pos   = AW2'(6 * seg_r) + AW2'(o_r);
  always_comb begin
    rd_addr = '0;
    if (state_r == ST_SRCH) begin
      rd_addr = bes_pkg::ADDR_W'(srch_pos);
    end else if (ld_pos >= AW2'(2) && (ld_pos - AW2'(2)) < AW2'(bes_pkg::WORD_DEPTH)) begin
      rd_addr = bes_pkg::ADDR_W'(ld_pos - AW2'(2));
    end
  end

  // curve store: write on word transfer, registered read
  always_ff @(posedge clk) begin
    if (in_xfer && !is_sample && 32'(in_ch.word_index) < bes_pkg::WORD_DEPTH) begin
      mem[bes_pkg::ADDR_W'(in_ch.word_index)] <= in_ch.word_value;
    end
    rdata_r <= mem[rd_addr];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_BIS) begin
      unique case (op_r)
        5'd0:  begin mul_a = 32'(p_r);  mul_b = 32'(p_r);  end
        5'd1:  begin mul_a = 32'(u_r);  mul_b = 32'(u_r);  end
        5'd2:  begin mul_a = 32'(p_r);  mul_b = 32'(p2_r); end
        5'd3:  begin mul_a = 32'(u_r);  mul_b = 32'(p2_r); end
        5'd4:  begin mul_a = 32'(u_r);  mul_b = 32'(u2_r); end
        5'd5:  begin mul_a = 32'(p_r);  mul_b = 32'(u2_r); end
        5'd6:  begin mul_a = 32'(ka_r); mul_b = 32'(cx_r[0]); end
        5'd7:  begin mul_a = 32'(kb_r); mul_b = 32'(cx_r[1]); end
        5'd8:  begin mul_a = 32'(kc_r); mul_b = 32'(cx_r[2]); end
        5'd9:  begin mul_a = 32'(kd_r); mul_b = 32'(cx_r[3]); end
        5'd10: begin mul_a = 32'(ka_r); mul_b = 32'(cy_r[0]); end
        5'd11: begin mul_a = 32'(kb_r); mul_b = 32'(cy_r[1]); end
        5'd12: begin mul_a = 32'(kc_r); mul_b = 32'(cy_r[2]); end
        OP_LAST_MUL: begin mul_a = 32'(kd_r); mul_b = 32'(cy_r[3]); end
        default: ;
      endcase
    end else if (state_r == ST_FIN_M) begin
      mul_a = 32'(y_mag);
      mul_b = 32'(SCALE);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // rounding of the registered product
  assign rnd_u  = P_W'((prod_r[63:0] + 64'(HALF30)) >> 30);
  assign prod3  = {2'b0, prod_r} + {1'b0, prod_r, 1'b0} + 66'(HALF30);
  assign rnd_3u = P_W'(prod3 >> 30);
  assign x_cur  = XY_W'((accx_r + ACC_W'(HALF30)) >>> 30);
  assign y_cur  = XY_W'((accy_r + ACC_W'(HALF30)) >>> 30);
  assign go_lo  = $signed({2'b00, t_r}) > 35'(x_cur);
  assign mid    = P_W'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign last_seg = (CNT_W_L'(seg_r) + 1'b1) == n_r;

  // final saturation and integer rounding
  always_comb begin
    priority if (y_r > XY_W'(8388607)) y_sat = C_W'(8388607);
    else if (y_r < -XY_W'(8388608)) y_sat = -C_W'(8388608);
    else y_sat = C_W'(y_r);
  end
  assign y_mag = y_sat[C_W-1] ? C_W'(-y_sat) : C_W'(y_sat);
  assign r_int = C_W'((prod_r[39:0] + 40'd32768) >> 16);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_xfer && is_sample) state_nxt = ST_DIV;
      ST_DIV:    if (div_sts.done) state_nxt = ST_SRCH;
      ST_SRCH:   state_nxt = ((CNT_W_L'(k_r) + 1'b1) >= n_r) ? ST_LD_A : ST_SRCH_D;
      ST_SRCH_D: state_nxt = ($signed(35'(rdata_r)) >= $signed({2'b00, t_r}))
                             ? ST_LD_A : ST_SRCH;
      ST_LD_A:   state_nxt = ST_LD_D;
      ST_LD_D:   state_nxt = (o_r == 3'd7) ? ST_BIS : ST_LD_A;
      ST_BIS:    if (op_r == OP_NEXT && step_r == bes_pkg::STEP_W'(bes_pkg::BISECT_STEPS - 1))
                   state_nxt = ST_FIN_M;
      ST_FIN_M:  state_nxt = ST_FIN_R;
      ST_FIN_R:  state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_sample) begin
          sidx_r <= in_ch.sample_index;
          n_r    <= n_eff;
        end
        k_r <= '0;
      end
      ST_DIV: begin
        t_r <= div_quo;
      end
      ST_SRCH: begin
        seg_r <= k_r;
        o_r   <= '0;
      end
      ST_SRCH_D: begin
        if (!($signed(35'(rdata_r)) >= $signed({2'b00, t_r}))) k_r <= k_r + 1'b1;
      end
      ST_LD_A: ;
      ST_LD_D: begin
        // start and end points are fixed at the ends of the curve
        if (o_r[2:1] == 2'd0 && seg_r == '0) begin
          if (o_r[0]) cy_r[0] <= '0; else cx_r[0] <= '0;
        end else if (o_r[2:1] == 2'd3 && last_seg) begin
          if (o_r[0]) cy_r[3] <= C_W'(65536); else cx_r[3] <= C_W'(65536);
        end else begin
          if (o_r[0]) cy_r[o_r[2:1]] <= rdata_r; else cx_r[o_r[2:1]] <= rdata_r;
        end
        o_r    <= o_r + 1'b1;
        lo_r   <= '0;
        hi_r   <= ONE30;
        p_r    <= HALF30;
        u_r    <= HALF30;
        op_r   <= '0;
        step_r <= '0;
      end
      ST_BIS: begin
        op_r <= (op_r == OP_NEXT) ? '0 : op_r + 1'b1;
        unique case (op_r)
          5'd1:  p2_r <= rnd_u;
          5'd2:  u2_r <= rnd_u;
          5'd3:  kd_r <= rnd_u;
          5'd4:  kc_r <= rnd_3u;
          5'd5:  ka_r <= rnd_u;
          5'd6:  kb_r <= rnd_3u;
          5'd7:  accx_r <= ACC_W'(prod_r);
          5'd8, 5'd9, 5'd10:  accx_r <= accx_r + ACC_W'(prod_r);
          5'd11: accy_r <= ACC_W'(prod_r);
          5'd12, 5'd13, 5'd14: accy_r <= accy_r + ACC_W'(prod_r);
          OP_DECIDE: begin
            y_r <= y_cur;
            if (go_lo) lo_r <= p_r; else hi_r <= p_r;
          end
          OP_NEXT: begin
            p_r    <= mid;
            u_r    <= ONE30 - mid;
            step_r <= step_r + 1'b1;
          end
          default: ;
        endcase
      end
      ST_FIN_M: ;
      ST_FIN_R: begin
        res_r <= int_out_r ? (y_sat[C_W-1] ? C_W'(-r_int) : r_int) : y_sat;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_value_r <= res_r;
          out_idx_r   <= sidx_r;
        end
      end
      default: ;
    endcase
  end

  // bracket stays ordered while bisecting
  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BIS |-> lo_r < hi_r)
    else $error("bisection bracket collapsed");

  // chosen segment lies within the active ones
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LD_A |-> CNT_W_L'(seg_r) < n_r)
    else $error("segment beyond active count");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV)
    else $error("divider result outside divide phase");

  // a held result is never overwritten before transfer
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_value_r) && $stable(out_idx_r))
    else $error("pending result overwritten");

  // a new sample cannot start while the divider is still running
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

endmodule
